@@ hdl/lppm_pkg.sv @@
// lppm_pkg: shared types, constants and hash operand function for the pointer map
// no dependencies
package lppm_pkg;

   localparam int CAPACITY = 64;
   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int COUNT_W = SLOT_W + 1;
   localparam int KEY_SHIFT = 5;
   localparam int HASH_SHIFT = 32;
   localparam int LOAD_DIV = 2;
   localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_REMOVED = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_INVALID = 3'd4;

   typedef logic [SLOT_W-1:0] slot_type;

   // datapath commands
   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,     // capture request, start hash
      DP_HASH,     // finish hash, set probe pointer to home
      DP_READ,     // issue read at probe pointer
      DP_NEXT,     // advance probe pointer
      DP_WRITE_IN, // write request entry at probe pointer
      DP_FOUND,    // capture found entry, hole = ptr, ptr = ptr + 1
      DP_SHIFT     // move entry at ptr into hole, hole = ptr
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic clear_hole; // clear valid bit at hole, so its key reads as zero
      logic count_inc;
      logic count_dec;
      logic rehash;     // start hashing the key just read
   } dp_cmd_type;

   typedef struct packed {
      logic key_zero;   // request key is zero
      logic is_remove;
      logic full;
      logic rd_empty;   // read key is zero
      logic rd_match;   // read key equals request key
      logic shift_ok;   // entry read may move into hole
      logic wrapped;    // probe counter covered the table
   } dp_sts_type;

   function automatic logic [63:0] hash_operand(input logic [63:0] key);
      hash_operand = key >> KEY_SHIFT;
   endfunction

endpackage

@@ hdl/lppm_datapath.sv @@
// lppm_datapath: table memories, hash multiplier, probe pointers and result
// depends on lppm_pkg
module lppm_datapath import lppm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_sts_type  sts,
   input  logic        req_command,
   input  logic [63:0] req_key_addr,
   input  logic [63:0] req_base_in,
   input  logic [63:0] req_size_in,
   input  logic        res_load,
   input  logic [2:0]  res_status,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_base_out,
   output logic [63:0] rsp_size_out
);

   logic [63:0] key_mem [CAPACITY];
   logic [63:0] base_mem [CAPACITY];
   logic [63:0] size_mem [CAPACITY];
   logic [CAPACITY-1:0] valid_ff;

   logic        cmd_ff;
   logic [63:0] key_ff, base_ff, size_ff;
   logic [63:0] fbase_ff, fsize_ff;
   logic [63:0] rkey_ff, rbase_ff, rsize_ff;
   logic        rvalid_ff;
   logic [31:0] plo_ff, phi_ff, pmid_ff;
   slot_type    ptr_ff, hole_ff;
   logic [COUNT_W-1:0] probe_ff, count_ff;
   logic [63:0] hash_src;
   logic [63:0] rkey_eff;
   logic [31:0] hash_w;
   slot_type    home_w;

   // key read is gated by valid bits, entries not valid read as empty
   assign rkey_eff = rvalid_ff ? rkey_ff : 64'd0;

   // hash operand: request key or key just read during shifting
   assign hash_src = cmd.rehash ? hash_operand(rkey_eff) : hash_operand(key_ff);

   // bits 32 and up of product: hi32 of (lo*lo) + lo*hi + hi*lo, low bits
   assign hash_w = phi_ff + pmid_ff + plo_ff;
   assign home_w = hash_w[SLOT_W-1:0];

   // hash stage one: three 32x32 partial products, registered
   always_ff @(posedge clock) begin
      logic [63:0] ll;
      logic [31:0] lh, hl;
      ll = 64'(hash_src[31:0]) * 64'(HASH_MULT[31:0]);
      lh = 32'(hash_src[31:0] * HASH_MULT[63:32]);
      hl = 32'(hash_src[63:32] * HASH_MULT[31:0]);
      plo_ff <= ll[63:32];
      phi_ff <= lh;
      pmid_ff <= hl;
   end

   // registered memory read at probe pointer
   always_ff @(posedge clock) begin
      rkey_ff <= key_mem[ptr_ff];
      rbase_ff <= base_mem[ptr_ff];
      rsize_ff <= size_mem[ptr_ff];
      rvalid_ff <= valid_ff[ptr_ff];
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.op == DP_WRITE_IN) begin
         key_mem[ptr_ff] <= key_ff;
         base_mem[ptr_ff] <= base_ff;
         size_mem[ptr_ff] <= size_ff;
      end else if (cmd.op == DP_SHIFT) begin
         key_mem[hole_ff] <= rkey_eff;
         base_mem[hole_ff] <= rbase_ff;
         size_mem[hole_ff] <= rsize_ff;
      end
   end

   // valid bits, clear at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.op == DP_WRITE_IN || cmd.op == DP_SHIFT) begin
         valid_ff[(cmd.op == DP_WRITE_IN) ? ptr_ff : hole_ff] <= 1'b1;
      end else if (cmd.clear_hole) begin
         valid_ff[hole_ff] <= 1'b0;
      end
   end

   // request capture, pointers, entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.count_dec && count_ff != '0) begin
         count_ff <= count_ff - 1'b1;
      end
      case (cmd.op)
         DP_LOAD: begin
            cmd_ff <= req_command;
            key_ff <= req_key_addr;
            base_ff <= req_base_in;
            size_ff <= req_size_in;
         end
         DP_HASH: begin
            ptr_ff <= home_w;
            probe_ff <= '0;
         end
         DP_NEXT: begin
            ptr_ff <= ptr_ff + 1'b1;
            probe_ff <= probe_ff + 1'b1;
         end
         DP_FOUND: begin
            fbase_ff <= rbase_ff;
            fsize_ff <= rsize_ff;
            hole_ff <= ptr_ff;
            ptr_ff <= ptr_ff + 1'b1;
            probe_ff <= '0;
         end
         DP_SHIFT: begin
            hole_ff <= ptr_ff;
            ptr_ff <= ptr_ff + 1'b1;
            probe_ff <= probe_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // status to controller
   always_comb begin
      slot_type d_home, d_hole;
      d_home = ptr_ff - home_w;
      d_hole = ptr_ff - hole_ff;
      sts.key_zero = (key_ff == 64'd0);
      sts.is_remove = cmd_ff;
      sts.full = ((COUNT_W+1)'(count_ff) + 1'b1) * LOAD_DIV > (COUNT_W+1)'(CAPACITY);
      sts.rd_empty = (rkey_eff == 64'd0);
      sts.rd_match = (rkey_eff == key_ff);
      sts.shift_ok = (d_home >= d_hole);
      sts.wrapped = (probe_ff == COUNT_W'(CAPACITY - 1));
   end

   // result register
   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_status <= res_status;
         rsp_base_out <= (res_status == ST_REMOVED) ? fbase_ff : key_ff;
         rsp_size_out <= (res_status == ST_REMOVED) ? fsize_ff : 64'd0;
      end
   end

endmodule

@@ hdl/lppm_ctrl.sv @@
// lppm_ctrl: sequencer for insert, find and backward shift deletion
// depends on lppm_pkg
module lppm_ctrl import lppm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd,
   output logic       res_load,
   output logic [2:0] res_status
);

   typedef enum logic [3:0] {
      S_IDLE, S_HASH1, S_HASH2, S_RD, S_WAIT, S_CHECK,
      S_E_RD, S_E_WAIT, S_E_HASH1, S_E_HASH2, S_E_CHECK, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [2:0] status_ff, status_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      cmd = '{op: DP_NOP, clear_hole: 1'b0, count_inc: 1'b0,
              count_dec: 1'b0, rehash: 1'b0};
      res_load = 1'b0;
      res_status = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = DP_LOAD;
               state_in = S_HASH1;
            end
         end
         S_HASH1: state_in = S_HASH2;
         S_HASH2: begin
            cmd.op = DP_HASH;
            state_in = S_RD;
            if (sts.key_zero || (!sts.is_remove && sts.full)) begin
               cmd.op = DP_NOP;
               state_in = S_DONE;
               status_in = sts.key_zero ? ST_INVALID : ST_FULL;
            end
         end
         S_RD: state_in = S_WAIT;
         S_WAIT: state_in = S_CHECK;
         S_CHECK: begin
            if (!sts.is_remove) begin
               if (sts.rd_empty) begin
                  cmd.op = DP_WRITE_IN;
                  cmd.count_inc = 1'b1;
                  status_in = ST_INSERTED;
                  state_in = S_DONE;
               end else if (sts.wrapped) begin
                  status_in = ST_INSERTED;
                  state_in = S_DONE;
               end else begin
                  cmd.op = DP_NEXT;
                  state_in = S_RD;
               end
            end else if (sts.rd_empty) begin
               status_in = ST_NOT_FOUND;
               state_in = S_DONE;
            end else if (sts.rd_match) begin
               cmd.op = DP_FOUND;
               status_in = ST_REMOVED;
               state_in = S_E_RD;
            end else if (sts.wrapped) begin
               status_in = ST_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               cmd.op = DP_NEXT;
               state_in = S_RD;
            end
         end
         S_E_RD: state_in = S_E_WAIT;
         S_E_WAIT: begin
            cmd.rehash = 1'b1;
            state_in = S_E_HASH1;
         end
         S_E_HASH1: begin
            cmd.rehash = 1'b1;
            state_in = S_E_HASH2;
         end
         S_E_HASH2: begin
            cmd.rehash = 1'b1;
            state_in = S_E_CHECK;
         end
         S_E_CHECK: begin
            if (sts.rd_empty || sts.wrapped) begin
               cmd.clear_hole = 1'b1;
               cmd.count_dec = 1'b1;
               state_in = S_DONE;
            end else begin
               if (sts.shift_ok) begin
                  cmd.op = DP_SHIFT;
               end else begin
                  cmd.op = DP_NEXT;
               end
               state_in = S_E_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         status_ff <= ST_INSERTED;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff <= status_in;
      end
   end

   // a stalled response stays valid
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_stall |=> rsp_valid);

   // a new response is loaded only when the output register is free
   assert property (@(posedge clock) disable iff (reset) res_load |-> out_free);

   // an accepted transaction starts the hash
   assert property (@(posedge clock) disable iff (reset)
                    req_valid && !req_stall |=> state_ff == S_HASH1);

endmodule

@@ hdl/linear_probe_pointer_map.sv @@
// linear_probe_pointer_map: top level of the open addressing pointer map
// depends on lppm_pkg, lppm_ctrl, lppm_datapath
//
//   channel | ports                                   | dir
//   req     | req_valid req_stall req_command ...     | in
//   rsp     | rsp_valid rsp_stall rsp_status ...      | out
//
// one transaction at a time; each probed slot takes the read, wait and check states,
// a zero key or refused insert goes from the hash states straight to done, and removal
// walks the backward shift through read, wait, hash and check per slot, the final empty
// slot included; the response is loaded in done once the output register is free
// req_stall is high from acceptance until the response is loaded; a stalled response
// holds the next one back; synchronous reset clears state, entry count and valid bits
module linear_probe_pointer_map import lppm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [63:0] req_key_addr,
   input  logic [63:0] req_base_in,
   input  logic [63:0] req_size_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_base_out,
   output logic [63:0] rsp_size_out
);
   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       res_load;
   logic [2:0] res_status;

   lppm_ctrl u_ctrl (.*);
   lppm_datapath u_dp (.*);
endmodule

@@ bench/map_checker.sv @@
`timescale 1ns / 1ps
// map_checker: watches both channels of the pointer map, predicts each response
// from its own table copy and compares; depends on lppm_pkg
module map_checker import lppm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_command,
   input  logic [63:0] req_key_addr,
   input  logic [63:0] req_base_in,
   input  logic [63:0] req_size_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [63:0] rsp_base_out,
   input  logic [63:0] rsp_size_out,
   output int          fail_count,
   output int          pending_count,
   output logic        activity
);

   typedef struct {
      logic [2:0]  status;
      logic [63:0] base;
      logic [63:0] size;
   } map_answer_type;

   logic [63:0] key_copy [CAPACITY];
   logic [63:0] base_copy [CAPACITY];
   logic [63:0] size_copy [CAPACITY];
   int unsigned entries;
   map_answer_type answer_queue [$];

   function automatic int unsigned home_of(input logic [63:0] key);
      logic [63:0] prod;
      prod = (key >> KEY_SHIFT) * HASH_MULT;
      return int'(prod[63:HASH_SHIFT]) & (CAPACITY - 1);
   endfunction

   // apply one transaction to the table copy and return the answer
   function automatic map_answer_type apply_request(input logic cmd, input logic [63:0] key,
                                                    input logic [63:0] base,
                                                    input logic [63:0] size);
      map_answer_type a;
      int unsigned i, hole, home, n;
      bit found;
      a.status = ST_INVALID;
      a.base = key;
      a.size = '0;
      found = 0;
      if (key == 0) begin
         a.status = ST_INVALID;
      end else if (cmd == 1'b0) begin
         if ((entries + 1) * LOAD_DIV > CAPACITY) begin
            a.status = ST_FULL;
         end else begin
            i = home_of(key);
            for (n = 0; n < CAPACITY; n++) begin
               if (key_copy[i] == 0) begin
                  key_copy[i] = key;
                  base_copy[i] = base;
                  size_copy[i] = size;
                  entries++;
                  break;
               end
               i = (i + 1) & (CAPACITY - 1);
            end
            a.status = ST_INSERTED;
         end
      end else begin
         i = home_of(key);
         for (n = 0; n < CAPACITY; n++) begin
            if (key_copy[i] == 0) break;
            if (key_copy[i] == key) begin
               found = 1;
               break;
            end
            i = (i + 1) & (CAPACITY - 1);
         end
         if (!found) begin
            a.status = ST_NOT_FOUND;
         end else begin
            a.status = ST_REMOVED;
            a.base = base_copy[i];
            a.size = size_copy[i];
            // backward shift deletion
            hole = i;
            i = (hole + 1) & (CAPACITY - 1);
            for (n = 0; n < CAPACITY && key_copy[i] != 0; n++) begin
               home = home_of(key_copy[i]);
               if (((i - home) & (CAPACITY - 1)) >= ((i - hole) & (CAPACITY - 1))) begin
                  key_copy[hole] = key_copy[i];
                  base_copy[hole] = base_copy[i];
                  size_copy[hole] = size_copy[i];
                  hole = i;
               end
               i = (i + 1) & (CAPACITY - 1);
            end
            key_copy[hole] = 0;
            if (entries != 0) entries--;
         end
      end
      return a;
   endfunction

   assign pending_count = answer_queue.size();
   assign activity = (req_valid && !req_stall) || (rsp_valid && !rsp_stall);

   always @(posedge clock) begin
      map_answer_type want;
      if (reset) begin
         for (int k = 0; k < CAPACITY; k++) key_copy[k] = '0;
         entries = 0;
         fail_count <= 0;
         answer_queue.delete();
      end else begin
         // responses first: one transaction in flight, request cannot overtake
         if (rsp_valid && !rsp_stall) begin
            if (answer_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response status %0d base %h size %h",
                           rsp_status, rsp_base_out, rsp_size_out);
               fail_count <= fail_count + 1;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_status !== want.status || rsp_base_out !== want.base ||
                   rsp_size_out !== want.size) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %0d %h %h, got %0d %h %h",
                              want.status, want.base, want.size,
                              rsp_status, rsp_base_out, rsp_size_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            answer_queue.push_back(apply_request(req_command, req_key_addr,
                                                 req_base_in, req_size_in));
      end
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// testbench: stimulus and verdict for linear_probe_pointer_map
// depends on lppm_pkg, map_checker and the block itself
module testbench;
   import lppm_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_command = 0;
   logic [63:0] req_key_addr = '0;
   logic [63:0] req_base_in = '0;
   logic [63:0] req_size_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_base_out;
   logic [63:0] rsp_size_out;
   int          fail_count;
   int          pending_count;
   logic        activity;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          stall_enable = 1;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   logic [63:0] live_keys [$];

   always #6 clock = ~clock;

   linear_probe_pointer_map dut (.*);

   map_checker checker_inst (.*);

   // response side stall with occasional long stretches
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!stall_enable || $urandom_range(0, 3) != 0) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(10, 40);
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   // watchdog on cycles without any accepted request or response
   always @(posedge clock) begin
      if (activity || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // keys mostly drawn from a small pool so home slots collide often
   function automatic logic [63:0] pool_key();
      logic [63:0] k;
      k = {$urandom, $urandom};
      if ($urandom_range(0, 2) != 0) k = 64'h1000 + 64'($urandom_range(1, 200)) * 32;
      else k[4:0] = 5'd0;
      if (k == 0) k = 64'h20;
      return k;
   endfunction

   // valid drops only for a gap before a request, so back to back requests keep it high
   task automatic send(input logic cmd, input logic [63:0] key,
                       input logic [63:0] base, input logic [63:0] size);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key_addr <= key;
      req_base_in <= base;
      req_size_in <= size;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == CMD_INSERT && key != 0) live_keys.push_back(key);
   endtask

   initial begin
      logic [63:0] k;
      int idx;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero key, extremes, fill to half plus refused inserts, absent key, drain
      send(CMD_INSERT, 64'h0, '1, '1);
      send(CMD_REMOVE, 64'h0, '1, '1);
      send(CMD_REMOVE, 64'h1234_5678_9ABC_DEF0, '0, '0);
      send(CMD_INSERT, '1, '1, '1);
      send(CMD_INSERT, 64'h8000_0000_0000_0000, '0, '0);
      send(CMD_INSERT, 64'h20, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send(CMD_INSERT, 64'h20, 64'h1, 64'h2);
      send(CMD_REMOVE, 64'h20, '0, '0);
      send(CMD_REMOVE, '1, '0, '0);
      for (int n = 0; n < 34; n++)
         send(CMD_INSERT, 64'h40 + 64'(n) * 64'h20, {$urandom, $urandom}, {$urandom, $urandom});
      send(CMD_REMOVE, 64'h40, '0, '0);
      send(CMD_REMOVE, 64'h8000_0000_0000_0000, '0, '0);
      send(CMD_REMOVE, 64'h20, '0, '0);
      for (int n = 1; n < 34; n++) send(CMD_REMOVE, 64'h40 + 64'(n) * 64'h20, '0, '0);
      live_keys.delete();

      // random: mostly remove of live keys or insert from collision pool
      for (int n = 0; n < 470; n++) begin
         if (n == 300) stall_enable = 0;
         if (n == 380) stall_enable = 1;
         if ($urandom_range(0, 29) == 0) k = '0;
         else k = pool_key();
         if ($urandom_range(0, 1) == 0 && live_keys.size() > 0 && $urandom_range(0, 4) != 0) begin
            idx = $urandom_range(0, live_keys.size() - 1);
            k = live_keys[idx];
            live_keys.delete(idx);
            send(CMD_REMOVE, k, {$urandom, $urandom}, {$urandom, $urandom});
         end else begin
            send(($urandom_range(0, 3) == 0) ? CMD_REMOVE : CMD_INSERT, k,
                 {$urandom, $urandom}, {$urandom, $urandom});
         end
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
